### rtl/core/pcsb_pkg.sv
// Shared types, constants and the region table for the corner-swap bin finder.
`timescale 1ns / 1ps
`default_nettype none

package pcsb_pkg;

    // Configuration port layout.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] REG_TANG = 2'd0;
    localparam logic [1:0] REG_VIEW = 2'd1;
    localparam logic [1:0] REG_MASH = 2'd2;

    localparam logic [9:0] TANG_RESET = 10'd288;
    localparam logic [9:0] VIEW_RESET = 10'd288;
    localparam logic [3:0] MASH_RESET = 4'd1;

    // Result status codes.
    localparam logic [2:0] ST_NEW_BIN   = 3'd0;
    localparam logic [2:0] ST_MODE_SKIP = 3'd1;
    localparam logic [2:0] ST_OUT_RANGE = 3'd2;
    localparam logic [2:0] ST_DUPLICATE = 3'd3;
    localparam logic [2:0] ST_BAD_VIEWS = 3'd4;
    localparam logic [2:0] ST_BIG_OFFSET = 3'd5;

    // Region table selection.
    localparam logic [1:0] SEL_16BLK = 2'd0;
    localparam logic [1:0] SEL_14BLK = 2'd1;
    localparam logic [1:0] SEL_12BLK = 2'd2;

    // Half-ring modes of a table row.
    localparam logic [1:0] MODE_BOTH  = 2'd0;
    localparam logic [1:0] MODE_UPPER = 2'd1;
    localparam logic [1:0] MODE_LOWER = 2'd2;

    // Shared divider geometry.
    localparam int DIV_DVD_W  = 17;
    localparam int DIV_DVS_W  = 15;
    localparam int DIV_STEP_W = 5;

    // Seen-bin bitmap row geometry.
    localparam int BMP_WORD_W = 32;
    localparam int BMP_SEL_W  = 5;

    // Width of the signed bin number before range checking.
    localparam int BIN_CALC_W = 26;

    typedef struct packed {
        logic [3:0] lo;
        logic [3:0] hi;
        logic [1:0] mode;
    } row_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_DVD_W-1:0] dividend;
        logic [DIV_DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_DVD_W-1:0] quotient;
        logic [DIV_DVS_W-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic lookup;
        logic mark;
    } bmp_req_t;

    typedef struct packed {
        logic clearing;
        logic hit;
    } bmp_rsp_t;

    function automatic row_t region_row(input logic [1:0] sel, input logic [2:0] region);
        row_t row;
        case ({sel, region})
            {SEL_16BLK, 3'd0}: row = {4'd0,  4'd5,  MODE_BOTH};
            {SEL_16BLK, 3'd1}: row = {4'd0,  4'd6,  MODE_BOTH};
            {SEL_16BLK, 3'd2}: row = {4'd0,  4'd7,  MODE_UPPER};
            {SEL_16BLK, 3'd3}: row = {4'd1,  4'd6,  MODE_UPPER};
            {SEL_16BLK, 3'd4}: row = {4'd10, 4'd15, MODE_BOTH};
            {SEL_16BLK, 3'd5}: row = {4'd9,  4'd15, MODE_BOTH};
            {SEL_16BLK, 3'd6}: row = {4'd8,  4'd15, MODE_LOWER};
            {SEL_16BLK, 3'd7}: row = {4'd9,  4'd14, MODE_LOWER};
            {SEL_14BLK, 3'd0}: row = {4'd0,  4'd4,  MODE_BOTH};
            {SEL_14BLK, 3'd1}: row = {4'd0,  4'd5,  MODE_BOTH};
            {SEL_14BLK, 3'd2}: row = {4'd0,  4'd6,  MODE_UPPER};
            {SEL_14BLK, 3'd3}: row = {4'd1,  4'd5,  MODE_UPPER};
            {SEL_14BLK, 3'd4}: row = {4'd9,  4'd13, MODE_BOTH};
            {SEL_14BLK, 3'd5}: row = {4'd8,  4'd13, MODE_BOTH};
            {SEL_14BLK, 3'd6}: row = {4'd8,  4'd12, MODE_LOWER};
            {SEL_14BLK, 3'd7}: row = {4'd7,  4'd13, MODE_LOWER};
            {SEL_12BLK, 3'd0}: row = {4'd0,  4'd3,  MODE_BOTH};
            {SEL_12BLK, 3'd1}: row = {4'd0,  4'd4,  MODE_BOTH};
            {SEL_12BLK, 3'd2}: row = {4'd0,  4'd5,  MODE_UPPER};
            {SEL_12BLK, 3'd3}: row = {4'd1,  4'd4,  MODE_UPPER};
            {SEL_12BLK, 3'd4}: row = {4'd8,  4'd11, MODE_BOTH};
            {SEL_12BLK, 3'd5}: row = {4'd7,  4'd11, MODE_BOTH};
            {SEL_12BLK, 3'd6}: row = {4'd7,  4'd10, MODE_LOWER};
            {SEL_12BLK, 3'd7}: row = {4'd6,  4'd11, MODE_LOWER};
            default:           row = {4'd0,  4'd0,  MODE_BOTH};
        endcase
        return row;
    endfunction

endpackage

`default_nettype wire

### rtl/core/pcsb_divider.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module pcsb_divider (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire pcsb_pkg::div_req_t req,
    output pcsb_pkg::div_rsp_t      rsp
);

    localparam int DVD_W = pcsb_pkg::DIV_DVD_W;
    localparam int DVS_W = pcsb_pkg::DIV_DVS_W;
    localparam int STP_W = pcsb_pkg::DIV_STEP_W;
    localparam logic [STP_W-1:0] STEP_LAST = STP_W'(DVD_W - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [STP_W-1:0] step_reg, step_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   shifted;
    logic [DVS_W+1:0] trial;

    // The dividend shifts out at the top while quotient bits shift in at the bottom.
    assign shifted = {rem_reg, dvd_reg[DVD_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            if (!trial[DVS_W+1]) begin
                rem_next = trial[DVS_W-1:0];
            end else begin
                rem_next = shifted[DVS_W-1:0];
            end
            dvd_next = {dvd_reg[DVD_W-2:0], ~trial[DVS_W+1]};
            if (step_reg == STEP_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = dvd_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

### rtl/core/pcsb_bitmap.sv
// Seen-bin bitmap: word-wide memory with a clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module pcsb_bitmap #(
    parameter int MAX_BINS = 262144
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire pcsb_pkg::bmp_req_t           req,
    input  wire logic [$clog2(MAX_BINS)-1:0]  index,
    output pcsb_pkg::bmp_rsp_t                rsp
);

    localparam int BIN_W  = $clog2(MAX_BINS);
    localparam int WORD_W = pcsb_pkg::BMP_WORD_W;
    localparam int SEL_W  = pcsb_pkg::BMP_SEL_W;
    localparam int ROW_W  = BIN_W - SEL_W;
    localparam int ROWS   = (MAX_BINS + WORD_W - 1) / WORD_W;
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

    logic [WORD_W-1:0] mem [ROWS];

    logic              clearing_reg, clearing_next;
    logic [ROW_W-1:0]  clr_row_reg, clr_row_next;
    logic [WORD_W-1:0] word_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [SEL_W-1:0]  sel_reg;

    always_comb begin
        clearing_next = clearing_reg;
        clr_row_next  = clr_row_reg;
        if (clearing_reg) begin
            if (clr_row_reg == ROW_LAST) begin
                clearing_next = 1'b0;
            end else begin
                clr_row_next = clr_row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_row_reg  <= '0;
        end else begin
            clearing_reg <= clearing_next;
            clr_row_reg  <= clr_row_next;
        end
    end

    // A lookup captures the row; a later mark writes it back with the bit set.
    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            mem[clr_row_reg] <= '0;
        end else if (req.mark) begin
            mem[row_reg] <= word_reg | (WORD_W'(1) << sel_reg);
        end
        if (req.lookup) begin
            word_reg <= mem[index[BIN_W-1:SEL_W]];
            row_reg  <= index[BIN_W-1:SEL_W];
            sel_reg  <= index[SEL_W-1:0];
        end
    end

    assign rsp.clearing = clearing_reg;
    assign rsp.hit      = word_reg[sel_reg];

endmodule

`default_nettype wire

### rtl/core/pet_corner_swap_bin_finder.sv
// Corner-swap bin finder top level: APB registers, sequencer, shared divider, bitmap.
// A bad view count or an oversized offset ends a transaction before the geometry, and a view
// count that is a multiple of nine adds a divider pass for the block size. Results that the
// mode or range checks drop skip the bitmap lookup. A new transaction is accepted only once the
// previous result has moved to the output register. Reset (synchronous, active low) restores the
// register defaults and clears the bitmap one 32-bit row per cycle, during which s_ready stays low.
`timescale 1ns / 1ps
`default_nettype none

module pet_corner_swap_bin_finder #(
    parameter int MAX_BINS = 262144
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [pcsb_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [pcsb_pkg::PDATA_W-1:0]    pwdata,
    output logic      [pcsb_pkg::PDATA_W-1:0]    prdata,
    output logic                                 pready,
    // Input channel
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [2:0]                      s_region,
    input  wire logic [9:0]                      s_det_a_offset,
    input  wire logic [9:0]                      s_det_b_offset,
    // Result channel
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [11:0]                          m_view_index,
    output logic signed [13:0]                   m_element_index,
    output logic [17:0]                          m_bin_offset,
    output logic [2:0]                           m_status,
    output logic [18:0]                          m_listed_count
);

    localparam int BIN_W = $clog2(MAX_BINS);
    localparam int BCW   = pcsb_pkg::BIN_CALC_W;
    localparam logic signed [BCW-1:0] MAX_BINS_S = BCW'(MAX_BINS);

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CFG   = 4'd1;
    localparam logic [3:0] S_BLK   = 4'd2;
    localparam logic [3:0] S_BLKW  = 4'd3;
    localparam logic [3:0] S_OFFS  = 4'd4;
    localparam logic [3:0] S_SORT  = 4'd5;
    localparam logic [3:0] S_SUM   = 4'd6;
    localparam logic [3:0] S_MODW  = 4'd7;
    localparam logic [3:0] S_ABS   = 4'd8;
    localparam logic [3:0] S_TE    = 4'd9;
    localparam logic [3:0] S_QWAIT = 4'd10;
    localparam logic [3:0] S_BIN   = 4'd11;
    localparam logic [3:0] S_CHECK = 4'd12;
    localparam logic [3:0] S_LOOKW = 4'd13;
    localparam logic [3:0] S_DONE  = 4'd14;

    logic [3:0]  state_reg, state_next;

    // Configuration registers.
    logic [9:0]  tang_reg, tang_next;
    logic [9:0]  view_reg, view_next;
    logic [3:0]  mash_reg, mash_next;

    // Captured transaction.
    logic [2:0]  region_reg, region_next;
    logic [9:0]  oa_reg, oa_next;
    logic [9:0]  ob_reg, ob_next;

    // View-count classification: quotients by 3, 7 and 9 via reciprocal products.
    logic [8:0]  q3_reg, q3_next;
    logic [7:0]  q7_reg, q7_next;
    logic [6:0]  q9_reg, q9_next;
    logic [13:0] nvm_reg, nvm_next;
    logic [1:0]  sel_reg, sel_next;
    logic        bad_reg, bad_next;
    logic        m7_reg, m7_next;
    logic        m9_reg, m9_next;

    // Geometry working registers.
    logic [11:0]              blk_reg, blk_next;
    pcsb_pkg::row_t           row_reg, row_next;
    logic [15:0]              da_reg, da_next;
    logic [15:0]              db_reg, db_next;
    logic [15:0]              x_reg, x_next;
    logic [15:0]              y_reg, y_next;
    logic signed [17:0]       diff_reg, diff_next;
    logic [13:0]              a_reg, a_next;
    logic [14:0]              b_reg, b_next;
    logic [16:0]              te_abs_reg, te_abs_next;
    logic signed [17:0]       te_reg, te_next;
    logic [23:0]              prod_reg, prod_next;
    logic signed [BCW-1:0]    bin_reg, bin_next;

    // Pending result and the listed-bin count.
    logic [11:0] res_view_reg, res_view_next;
    logic [13:0] res_elem_reg, res_elem_next;
    logic [17:0] res_bin_reg, res_bin_next;
    logic [2:0]  res_status_reg, res_status_next;
    logic [18:0] listed_reg, listed_next;

    // Output register.
    logic        m_valid_reg, m_valid_next;
    logic [11:0] m_view_reg, m_view_next;
    logic [13:0] m_elem_reg, m_elem_next;
    logic [17:0] m_bin_reg, m_bin_next;
    logic [2:0]  m_status_reg, m_status_next;
    logic [18:0] m_count_reg, m_count_next;

    // Shared units.
    pcsb_pkg::div_req_t div_req;
    pcsb_pkg::div_rsp_t div_rsp;
    pcsb_pkg::bmp_req_t bmp_req;
    pcsb_pkg::bmp_rsp_t bmp_rsp;

    // Combinational helpers.
    logic                  cfg_wr;
    logic [19:0]           p3;
    logic [21:0]           p7;
    logic [20:0]           p9;
    logic                  is_m3, is_m7, is_m9, is_even;
    pcsb_pkg::row_t        row_sel;
    logic                  neg_te;
    logic signed [17:0]    te_signed_abs;
    logic                  mode_skip;
    logic                  te_bad;
    logic                  bin_ok;

    pcsb_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    pcsb_bitmap #(
        .MAX_BINS (MAX_BINS)
    ) u_bitmap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (bmp_req),
        .index   (bin_reg[BIN_W-1:0]),
        .rsp     (bmp_rsp)
    );

    // A register write lands when setup and access phases complete; pready is tied high.
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb begin
        case (paddr[3:2])
            pcsb_pkg::REG_TANG: prdata = {22'd0, tang_reg};
            pcsb_pkg::REG_VIEW: prdata = {22'd0, view_reg};
            pcsb_pkg::REG_MASH: prdata = {28'd0, mash_reg};
            default:            prdata = '0;
        endcase
    end

    // Reciprocal products are exact floors for every 10-bit view count.
    assign p3 = {10'd0, view_reg} * 20'd683;
    assign p7 = {12'd0, view_reg} * 22'd2341;
    assign p9 = {11'd0, view_reg} * 21'd1821;

    assign is_even = ~view_reg[0];
    assign is_m3   = view_reg == ({1'b0, q3_reg} + {q3_reg, 1'b0});
    assign is_m7   = {1'b0, view_reg} == ({q7_reg, 3'b000} - {3'b000, q7_reg});
    assign is_m9   = view_reg == ({q9_reg, 3'b000} + {3'b000, q9_reg});

    assign row_sel = pcsb_pkg::region_row(sel_reg, region_reg);

    // The element changes sign when the pair does not straddle the view's ring split.
    assign neg_te        = ({2'b00, a_reg} > y_reg) || ({1'b0, b_reg} < x_reg);
    assign te_signed_abs = $signed({1'b0, te_abs_reg});

    assign mode_skip = ((row_reg.mode == pcsb_pkg::MODE_UPPER) &&
                        (a_reg < {1'b0, nvm_reg[13:1]})) ||
                       ((row_reg.mode == pcsb_pkg::MODE_LOWER) &&
                        (a_reg > {1'b0, nvm_reg[13:1]}));
    assign te_bad    = te_reg[17] || (te_reg >= $signed({8'd0, tang_reg}));
    assign bin_ok    = !bin_reg[BCW-1] && (bin_reg < MAX_BINS_S);

    always_comb begin
        state_next      = state_reg;
        tang_next       = tang_reg;
        view_next       = view_reg;
        mash_next       = mash_reg;
        region_next     = region_reg;
        oa_next         = oa_reg;
        ob_next         = ob_reg;
        q3_next         = q3_reg;
        q7_next         = q7_reg;
        q9_next         = q9_reg;
        nvm_next        = nvm_reg;
        sel_next        = sel_reg;
        bad_next        = bad_reg;
        m7_next         = m7_reg;
        m9_next         = m9_reg;
        blk_next        = blk_reg;
        row_next        = row_reg;
        da_next         = da_reg;
        db_next         = db_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        diff_next       = diff_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        te_abs_next     = te_abs_reg;
        te_next         = te_reg;
        prod_next       = prod_reg;
        bin_next        = bin_reg;
        res_view_next   = res_view_reg;
        res_elem_next   = res_elem_reg;
        res_bin_next    = res_bin_reg;
        res_status_next = res_status_reg;
        listed_next     = listed_reg;
        m_valid_next    = m_valid_reg;
        m_view_next     = m_view_reg;
        m_elem_next     = m_elem_reg;
        m_bin_next      = m_bin_reg;
        m_status_next   = m_status_reg;
        m_count_next    = m_count_reg;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        bmp_req.lookup   = 1'b0;
        bmp_req.mark     = 1'b0;

        if (cfg_wr) begin
            case (paddr[3:2])
                pcsb_pkg::REG_TANG: tang_next = pwdata[9:0];
                pcsb_pkg::REG_VIEW: view_next = pwdata[9:0];
                pcsb_pkg::REG_MASH: mash_next = pwdata[3:0];
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    region_next = s_region;
                    oa_next     = s_det_a_offset;
                    ob_next     = s_det_b_offset;
                    q3_next     = p3[19:11];
                    q7_next     = p7[21:14];
                    q9_next     = p9[20:14];
                    nvm_next    = {4'd0, view_reg} * {10'd0, mash_reg};
                    state_next  = S_CFG;
                end
            end
            S_CFG: begin
                // Later table rules override earlier ones.
                if (is_m3) begin
                    sel_next = pcsb_pkg::SEL_12BLK;
                end else if (is_m7) begin
                    sel_next = pcsb_pkg::SEL_14BLK;
                end else begin
                    sel_next = pcsb_pkg::SEL_16BLK;
                end
                bad_next   = !(is_even || is_m3 || is_m7) || (nvm_reg == 14'd0);
                m7_next    = is_m7;
                m9_next    = is_m9;
                state_next = S_BLK;
            end
            S_BLK: begin
                if (bad_reg) begin
                    res_view_next   = '0;
                    res_elem_next   = '0;
                    res_bin_next    = '0;
                    res_status_next = pcsb_pkg::ST_BAD_VIEWS;
                    state_next      = S_DONE;
                end else if (m9_reg) begin
                    // Detectors per ring over twelve equals view*mash over six.
                    div_req.start    = 1'b1;
                    div_req.dividend = {3'd0, nvm_reg};
                    div_req.divisor  = 15'd6;
                    state_next       = S_BLKW;
                end else begin
                    blk_next   = m7_reg ? 12'd56 : 12'd32;
                    state_next = S_OFFS;
                end
            end
            S_BLKW: begin
                if (div_rsp.done) begin
                    blk_next   = div_rsp.quotient[11:0];
                    state_next = S_OFFS;
                end
            end
            S_OFFS: begin
                if (({2'b00, oa_reg} >= blk_reg) || ({2'b00, ob_reg} >= blk_reg)) begin
                    res_view_next   = '0;
                    res_elem_next   = '0;
                    res_bin_next    = '0;
                    res_status_next = pcsb_pkg::ST_BIG_OFFSET;
                    state_next      = S_DONE;
                end else begin
                    row_next   = row_sel;
                    da_next    = ({12'd0, row_sel.lo} * {4'd0, blk_reg}) + {6'd0, oa_reg};
                    db_next    = ({12'd0, row_sel.hi} * {4'd0, blk_reg}) + {6'd0, ob_reg};
                    state_next = S_SORT;
                end
            end
            S_SORT: begin
                if (da_reg > db_reg) begin
                    x_next = da_reg;
                    y_next = db_reg;
                end else begin
                    x_next = db_reg;
                    y_next = da_reg;
                end
                state_next = S_SUM;
            end
            S_SUM: begin
                // Detectors per ring is twice view*mash; half of it is view*mash.
                div_req.start    = 1'b1;
                div_req.dividend = {1'b0, x_reg} + {1'b0, y_reg} + {3'd0, nvm_reg} + 17'd1;
                div_req.divisor  = {nvm_reg, 1'b0};
                diff_next  = $signed({2'b00, x_reg}) - $signed({2'b00, y_reg})
                             - $signed({4'd0, nvm_reg});
                state_next = S_MODW;
            end
            S_MODW: begin
                if (div_rsp.done) begin
                    a_next     = div_rsp.remainder[14:1];
                    state_next = S_ABS;
                end
            end
            S_ABS: begin
                b_next      = {1'b0, a_reg} + {1'b0, nvm_reg};
                te_abs_next = diff_reg[17] ? 17'(-diff_reg) : diff_reg[16:0];
                state_next  = S_TE;
            end
            S_TE: begin
                te_next = (neg_te ? -te_signed_abs : te_signed_abs)
                          + $signed({9'd0, tang_reg[9:1]});
                div_req.start    = 1'b1;
                div_req.dividend = {3'd0, a_reg};
                div_req.divisor  = {11'd0, mash_reg};
                state_next       = S_QWAIT;
            end
            S_QWAIT: begin
                if (div_rsp.done) begin
                    prod_next  = {10'd0, div_rsp.quotient[13:0]} * {14'd0, tang_reg};
                    state_next = S_BIN;
                end
            end
            S_BIN: begin
                bin_next   = $signed({2'b00, prod_reg}) + BCW'(te_reg);
                state_next = S_CHECK;
            end
            S_CHECK: begin
                res_view_next = a_reg[11:0];
                res_elem_next = te_reg[13:0];
                res_bin_next  = bin_ok ? bin_reg[17:0] : 18'd0;
                if (mode_skip) begin
                    res_status_next = pcsb_pkg::ST_MODE_SKIP;
                    state_next      = S_DONE;
                end else if (te_bad || !bin_ok) begin
                    res_status_next = pcsb_pkg::ST_OUT_RANGE;
                    state_next      = S_DONE;
                end else begin
                    bmp_req.lookup = 1'b1;
                    state_next     = S_LOOKW;
                end
            end
            S_LOOKW: begin
                if (bmp_rsp.hit) begin
                    res_status_next = pcsb_pkg::ST_DUPLICATE;
                end else begin
                    bmp_req.mark    = 1'b1;
                    listed_next     = listed_reg + 1'b1;
                    res_status_next = pcsb_pkg::ST_NEW_BIN;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                // Hand the result to the output register once it is free or draining.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_view_next   = res_view_reg;
                    m_elem_next   = res_elem_reg;
                    m_bin_next    = res_bin_reg;
                    m_status_next = res_status_reg;
                    m_count_next  = listed_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            tang_reg    <= pcsb_pkg::TANG_RESET;
            view_reg    <= pcsb_pkg::VIEW_RESET;
            mash_reg    <= pcsb_pkg::MASH_RESET;
            listed_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tang_reg    <= tang_next;
            view_reg    <= view_next;
            mash_reg    <= mash_next;
            listed_reg  <= listed_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        region_reg     <= region_next;
        oa_reg         <= oa_next;
        ob_reg         <= ob_next;
        q3_reg         <= q3_next;
        q7_reg         <= q7_next;
        q9_reg         <= q9_next;
        nvm_reg        <= nvm_next;
        sel_reg        <= sel_next;
        bad_reg        <= bad_next;
        m7_reg         <= m7_next;
        m9_reg         <= m9_next;
        blk_reg        <= blk_next;
        row_reg        <= row_next;
        da_reg         <= da_next;
        db_reg         <= db_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        diff_reg       <= diff_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        te_abs_reg     <= te_abs_next;
        te_reg         <= te_next;
        prod_reg       <= prod_next;
        bin_reg        <= bin_next;
        res_view_reg   <= res_view_next;
        res_elem_reg   <= res_elem_next;
        res_bin_reg    <= res_bin_next;
        res_status_reg <= res_status_next;
        m_view_reg     <= m_view_next;
        m_elem_reg     <= m_elem_next;
        m_bin_reg      <= m_bin_next;
        m_status_reg   <= m_status_next;
        m_count_reg    <= m_count_next;
    end

    // New transactions wait for the bitmap clearing pass after reset.
    assign s_ready         = (state_reg == S_IDLE) && !bmp_rsp.clearing;
    assign m_valid         = m_valid_reg;
    assign m_view_index    = m_view_reg;
    assign m_element_index = $signed(m_elem_reg);
    assign m_bin_offset    = m_bin_reg;
    assign m_status        = m_status_reg;
    assign m_listed_count  = m_count_reg;

endmodule

`default_nettype wire

### bench/pcsb_bin_checker.sv
// Checker for the corner-swap bin finder: tracks registers, predicts each result and compares.
`timescale 1ns / 1ps

module pcsb_bin_checker #(
    parameter int MAX_BINS = 262144
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pcsb_pkg::PADDR_W-1:0]     paddr,
    input  logic [pcsb_pkg::PDATA_W-1:0]     pwdata,
    input  logic                             pready,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic [2:0]                       s_region,
    input  logic [9:0]                       s_det_a_offset,
    input  logic [9:0]                       s_det_b_offset,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [11:0]                      m_view_index,
    input  logic signed [13:0]               m_element_index,
    input  logic [17:0]                      m_bin_offset,
    input  logic [2:0]                       m_status,
    input  logic [18:0]                      m_listed_count,
    output int                               mismatch_count,
    output int                               outstanding,
    output int                               results_checked,
    output int                               bins_marked,
    output int                               repeats_seen,
    output int                               dropped_seen,
    output int                               rejected_seen
);

    typedef struct packed {
        logic [11:0]        view;
        logic signed [13:0] element;
        logic [17:0]        bin;
        logic [2:0]         status;
        logic [18:0]        listed;
    } bin_result_t;

    // Block-pair rows {first block, second block, half-ring mode}, indexed by {table, region}.
    localparam logic [0:23][9:0] REGION_ROWS = {
        {4'd0,  4'd5,  pcsb_pkg::MODE_BOTH}, {4'd0,  4'd6,  pcsb_pkg::MODE_BOTH},
        {4'd0,  4'd7,  pcsb_pkg::MODE_UPPER}, {4'd1,  4'd6,  pcsb_pkg::MODE_UPPER},
        {4'd10, 4'd15, pcsb_pkg::MODE_BOTH}, {4'd9,  4'd15, pcsb_pkg::MODE_BOTH},
        {4'd8,  4'd15, pcsb_pkg::MODE_LOWER}, {4'd9,  4'd14, pcsb_pkg::MODE_LOWER},
        {4'd0,  4'd4,  pcsb_pkg::MODE_BOTH}, {4'd0,  4'd5,  pcsb_pkg::MODE_BOTH},
        {4'd0,  4'd6,  pcsb_pkg::MODE_UPPER}, {4'd1,  4'd5,  pcsb_pkg::MODE_UPPER},
        {4'd9,  4'd13, pcsb_pkg::MODE_BOTH}, {4'd8,  4'd13, pcsb_pkg::MODE_BOTH},
        {4'd8,  4'd12, pcsb_pkg::MODE_LOWER}, {4'd7,  4'd13, pcsb_pkg::MODE_LOWER},
        {4'd0,  4'd3,  pcsb_pkg::MODE_BOTH}, {4'd0,  4'd4,  pcsb_pkg::MODE_BOTH},
        {4'd0,  4'd5,  pcsb_pkg::MODE_UPPER}, {4'd1,  4'd4,  pcsb_pkg::MODE_UPPER},
        {4'd8,  4'd11, pcsb_pkg::MODE_BOTH}, {4'd7,  4'd11, pcsb_pkg::MODE_BOTH},
        {4'd7,  4'd10, pcsb_pkg::MODE_LOWER}, {4'd6,  4'd11, pcsb_pkg::MODE_LOWER}
    };

    logic [9:0]  tang_cfg;
    logic [9:0]  view_cfg;
    logic [3:0]  mash_cfg;
    bit          seen_bins [MAX_BINS];
    int          listed_total;
    bin_result_t expected_bins [$];

    assign bins_marked = listed_total;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
                 results_checked, what, got, want);
    endtask

    // Maps one detector pair to its sinogram bin and updates the seen-bin bitmap.
    function automatic bin_result_t locate_bin(input logic [2:0] region,
                                               input logic [9:0] off_a,
                                               input logic [9:0] off_b);
        longint      views, mash, tang, ndets, blk, da, db, far_det, near_det;
        longint      half_ring, a, b, te, half_views, bin_no;
        logic [1:0]  sel;
        logic        have_table;
        logic [9:0]  row;
        bin_result_t res;
        views = view_cfg;
        mash = mash_cfg;
        tang = tang_cfg;
        ndets = views * 2 * mash;
        blk = 32;
        sel = pcsb_pkg::SEL_16BLK;
        have_table = 1'b0;
        if (views % 2 == 0) begin
            sel = pcsb_pkg::SEL_16BLK;
            have_table = 1'b1;
        end
        if (views % 7 == 0) begin
            sel = pcsb_pkg::SEL_14BLK;
            blk = 56;
            have_table = 1'b1;
        end
        if (views % 3 == 0) begin
            sel = pcsb_pkg::SEL_12BLK;
            have_table = 1'b1;
        end
        if (views % 9 == 0)
            blk = ndets / 12;
        res = '0;
        res.listed = listed_total[18:0];
        if (!have_table || ndets == 0) begin
            res.status = pcsb_pkg::ST_BAD_VIEWS;
            return res;
        end
        if (longint'(off_a) >= blk || longint'(off_b) >= blk) begin
            res.status = pcsb_pkg::ST_BIG_OFFSET;
            return res;
        end
        row = REGION_ROWS[{sel, region}];
        da = longint'(row[9:6]) * blk + longint'(off_a);
        db = longint'(row[5:2]) * blk + longint'(off_b);
        far_det = (da > db) ? da : db;
        near_det = (da > db) ? db : da;
        half_ring = ndets / 2;
        a = ((far_det + near_det + half_ring + 1) % ndets) / 2;
        b = a + half_ring;
        te = far_det - near_det - half_ring;
        if (te < 0)
            te = -te;
        if (near_det < a || b < far_det)
            te = -te;
        te = te + tang / 2;
        bin_no = (a / mash) * tang + te;
        half_views = views * mash / 2;
        res.view = a[11:0];
        res.element = te[13:0];
        if (bin_no >= 0 && bin_no < MAX_BINS)
            res.bin = bin_no[17:0];
        if ((row[1:0] == pcsb_pkg::MODE_UPPER && a < half_views) ||
            (row[1:0] == pcsb_pkg::MODE_LOWER && a > half_views)) begin
            res.status = pcsb_pkg::ST_MODE_SKIP;
        end else if (te < 0 || te >= tang || bin_no < 0 || bin_no >= MAX_BINS) begin
            res.status = pcsb_pkg::ST_OUT_RANGE;
        end else if (seen_bins[bin_no]) begin
            res.status = pcsb_pkg::ST_DUPLICATE;
        end else begin
            seen_bins[bin_no] = 1'b1;
            listed_total++;
            res.status = pcsb_pkg::ST_NEW_BIN;
        end
        res.listed = listed_total[18:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        bin_result_t want;
        if (!aresetn) begin
            // The bitmap starts out clear and reset is applied only once.
            tang_cfg = pcsb_pkg::TANG_RESET;
            view_cfg = pcsb_pkg::VIEW_RESET;
            mash_cfg = pcsb_pkg::MASH_RESET;
            listed_total = 0;
            expected_bins.delete();
            outstanding <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[pcsb_pkg::PADDR_W-1:2])
                    pcsb_pkg::REG_TANG: tang_cfg = pwdata[9:0];
                    pcsb_pkg::REG_VIEW: view_cfg = pwdata[9:0];
                    pcsb_pkg::REG_MASH: mash_cfg = pwdata[3:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_bins.push_back(locate_bin(s_region, s_det_a_offset, s_det_b_offset));
            if (m_valid && m_ready) begin
                results_checked++;
                if (expected_bins.size() == 0) begin
                    report_mismatch("result with nothing pending, status", m_status, '0);
                end else begin
                    want = expected_bins.pop_front();
                    if (m_view_index !== want.view)
                        report_mismatch("view_index", m_view_index, want.view);
                    if (m_element_index !== want.element)
                        report_mismatch("element_index", m_element_index, want.element);
                    if (m_bin_offset !== want.bin)
                        report_mismatch("bin_offset", m_bin_offset, want.bin);
                    if (m_status !== want.status)
                        report_mismatch("status", m_status, want.status);
                    if (m_listed_count !== want.listed)
                        report_mismatch("listed_count", m_listed_count, want.listed);
                    case (want.status)
                        pcsb_pkg::ST_DUPLICATE: repeats_seen++;
                        pcsb_pkg::ST_MODE_SKIP, pcsb_pkg::ST_OUT_RANGE: dropped_seen++;
                        pcsb_pkg::ST_BAD_VIEWS, pcsb_pkg::ST_BIG_OFFSET: rejected_seen++;
                        default: ;
                    endcase
                end
            end
            outstanding <= expected_bins.size();
        end
    end

endmodule

### bench/testbench.sv
// Top of the corner-swap bin finder bench: clock, reset, register writes, pair traffic, verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int BIN_CAPACITY = 262144;

    // Clock and reset. The block clears its bitmap after reset, so the first
    // transaction simply waits for s_ready like any other.
    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    // Configuration port. pready is always high on this block.
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [pcsb_pkg::PADDR_W-1:0]   paddr = '0;
    logic [pcsb_pkg::PDATA_W-1:0]   pwdata = '0;
    logic [pcsb_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;

    // Detector-pair channel into the block.
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_region = '0;
    logic [9:0]  s_det_a_offset = '0;
    logic [9:0]  s_det_b_offset = '0;

    // Result channel out of the block.
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [11:0]        m_view_index;
    logic signed [13:0] m_element_index;
    logic [17:0]        m_bin_offset;
    logic [2:0]         m_status;
    logic [18:0]        m_listed_count;

    // Counters handed back by the checker.
    int mismatch_count;
    int outstanding;
    int results_checked;
    int bins_marked;
    int repeats_seen;
    int dropped_seen;
    int rejected_seen;

    // Stimulus bookkeeping. While calm is set neither side idles.
    logic        calm = 1'b0;
    int          pairs_sent = 0;
    int          settings_used = 1;
    logic [22:0] recent_pairs [$];

    pet_corner_swap_bin_finder #(
        .MAX_BINS(BIN_CAPACITY)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_region        (s_region),
        .s_det_a_offset  (s_det_a_offset),
        .s_det_b_offset  (s_det_b_offset),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_view_index    (m_view_index),
        .m_element_index (m_element_index),
        .m_bin_offset    (m_bin_offset),
        .m_status        (m_status),
        .m_listed_count  (m_listed_count)
    );

    pcsb_bin_checker #(
        .MAX_BINS(BIN_CAPACITY)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_region        (s_region),
        .s_det_a_offset  (s_det_a_offset),
        .s_det_b_offset  (s_det_b_offset),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_view_index    (m_view_index),
        .m_element_index (m_element_index),
        .m_bin_offset    (m_bin_offset),
        .m_status        (m_status),
        .m_listed_count  (m_listed_count),
        .mismatch_count  (mismatch_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .bins_marked     (bins_marked),
        .repeats_seen    (repeats_seen),
        .dropped_seen    (dropped_seen),
        .rejected_seen   (rejected_seen)
    );

    always #5 aclk = ~aclk;

    // The result side stalls about 8 percent of the time, except in the calm stretch.
    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 8);
    end

    // Offers one detector pair and holds it until the block takes it. A random
    // gap in front of about a quarter of the transactions keeps the sender idle
    // between them. Every task here starts and ends on a rising edge, and the
    // handshake is judged on the values seen just before that edge.
    task automatic send_pair(input logic [2:0] region, input logic [9:0] off_a,
                             input logic [9:0] off_b);
        if (!calm && $urandom_range(0, 99) < 25) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_region <= region;
        s_det_a_offset <= off_a;
        s_det_b_offset <= off_b;
        do @(posedge aclk); while (!s_ready);
        pairs_sent++;
        recent_pairs.push_back({region, off_a, off_b});
        if (recent_pairs.size() > 64)
            void'(recent_pairs.pop_front());
    endtask

    // Stops offering pairs and waits until every result has come back. Each
    // pair yields exactly one result, so the block is idle at that point.
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // One register write: setup phase, access phase, then psel drops back to idle so
    // that back-to-back writes never touch psel twice in one step.
    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    // Runs one register setting with random traffic. Most transactions keep
    // both offsets inside the block size of this setting so that they reach
    // the geometry, the mode filter and the bitmap; some replay a recent pair
    // to provoke repeats, and the rest are unrestricted noise.
    task automatic run_setting(input logic [9:0] tang, input logic [9:0] views,
                               input logic [3:0] mash, input int count);
        int          span;
        int          roll;
        logic [2:0]  region;
        logic [9:0]  off_a;
        logic [9:0]  off_b;
        logic [22:0] pick;
        wait_idle();
        write_register(pcsb_pkg::REG_TANG, 32'(tang));
        write_register(pcsb_pkg::REG_VIEW, 32'(views));
        write_register(pcsb_pkg::REG_MASH, 32'(mash));
        settings_used++;
        recent_pairs.delete();
        span = (views % 9 == 0) ? 2 * views * mash / 12 : ((views % 7 == 0) ? 56 : 32);
        if (span < 1)
            span = 1;
        if (span > 1024)
            span = 1024;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 10 && recent_pairs.size() > 0) begin
                pick = recent_pairs[$urandom_range(0, recent_pairs.size() - 1)];
                region = pick[22:20];
                off_a = pick[19:10];
                off_b = pick[9:0];
            end else if (roll < 18) begin
                region = 3'($urandom_range(0, 7));
                off_a = 10'($urandom_range(0, 1023));
                off_b = 10'($urandom_range(0, 1023));
            end else begin
                region = 3'($urandom_range(0, 7));
                off_a = 10'($urandom_range(0, span - 1));
                off_b = 10'($urandom_range(0, span - 1));
            end
            send_pair(region, off_a, off_b);
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed pairs on the reset setting (288 tangential, 288 views,
        // mash 1: twelve-block table, block size 48). Every region at both
        // ends of the block, offsets just past the block on either side, the
        // all-ones offsets, and three repeated pairs.
        for (int r = 0; r < 8; r++)
            send_pair(3'(r), 10'd0, 10'd0);
        for (int r = 0; r < 8; r++)
            send_pair(3'(r), 10'd47, 10'd47);
        send_pair(3'd0, 10'd48, 10'd0);
        send_pair(3'd0, 10'd0, 10'd48);
        send_pair(3'd7, 10'd1023, 10'd1023);
        send_pair(3'd0, 10'd0, 10'd0);
        send_pair(3'd4, 10'd47, 10'd47);
        send_pair(3'd5, 10'd20, 10'd30);
        send_pair(3'd5, 10'd20, 10'd30);

        // Random traffic over a range of settings, extremes included: the
        // sixteen-block table at the top of the range, a view count that no
        // table accepts, the fourteen-block size, a view count divisible by
        // nine (block size from the ring), all-ones registers, zero views,
        // zero mash, zero tangential positions, and a return to the reset
        // setting to revisit bins already listed.
        run_setting(10'd512, 10'd512, 4'd8, 200);
        run_setting(10'd1, 10'd1, 4'd1, 25);
        calm <= 1'b1;
        run_setting(10'd300, 10'd336, 4'd2, 170);
        calm <= 1'b0;
        run_setting(10'd200, 10'd252, 4'd3, 170);
        run_setting(10'd1023, 10'd1023, 4'd15, 120);
        run_setting(10'd64, 10'd0, 4'd4, 20);
        run_setting(10'd128, 10'd96, 4'd0, 20);
        run_setting(10'd0, 10'd210, 4'd5, 40);
        run_setting(10'd96, 10'd98, 4'd1, 150);
        run_setting(10'd400, 10'd160, 4'd8, 120);
        run_setting(10'd288, 10'd288, 4'd1, 115);

        wait_idle();
        // Let any stray late result show up before the verdict.
        repeat (80) @(posedge aclk);

        $display("summary: %0d detector pairs over %0d register settings, %0d results checked",
                 pairs_sent, settings_used, results_checked);
        $display("summary: %0d bins listed, %0d repeats, %0d dropped, %0d rejected",
                 bins_marked, repeats_seen, dropped_seen, rejected_seen);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run, bitmap clear included.
    initial begin
        #8000000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
